@@ src/crast_pkg.sv @@
package crast_pkg;

  // Coordinate and arithmetic widths
  localparam int CoordBits = 10;
  localparam int DecBits   = CoordBits + 4;
  localparam int PixBits   = CoordBits + 2;
  localparam int ScrBits   = 11;
  localparam int ColorBits = 24;
  localparam int CmpBits   = (PixBits > ScrBits + 1) ? PixBits : ScrBits + 1;

  // Command codes
  localparam logic OpStart = 1'b0;
  localparam logic OpStep  = 1'b1;

  // Configuration register indexes
  localparam logic CfgScreenWidth  = 1'b0;
  localparam logic CfgScreenHeight = 1'b1;

  // Reset values of the screen size
  localparam logic [ScrBits-1:0] ScreenWidthRst  = ScrBits'(512);
  localparam logic [ScrBits-1:0] ScreenHeightRst = ScrBits'(384);

  // One octant position, handed from the front end to the point emitter
  typedef struct packed {
    logic [CoordBits-1:0] cx;
    logic [CoordBits-1:0] cy;
    logic [CoordBits-1:0] ox;
    logic [CoordBits-1:0] oy;
    logic [ColorBits-1:0] color;
    logic                 done;
  } octant_t;

endpackage

@@ src/circle_rasterizer.sv @@
// The first point of a command passes through the queue, the working entry register and the output register.
// The result channel carries one point per cycle while the receiver is ready, eight
// points for each command that draws; a step past the end of the circle plots no point.
// A two-entry queue between command front end and point emitter sets the overlap.
// Reset (async, active low) clears the circle state to zero, empties the queue
// and sets the screen size to 512 by 384.
module circle_rasterizer (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_idx_i,
  input  logic [crast_pkg::ScrBits-1:0]         cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  opcode_i,
  input  logic [crast_pkg::CoordBits-1:0]       center_x_i,
  input  logic [crast_pkg::CoordBits-1:0]       center_y_i,
  input  logic [crast_pkg::CoordBits-1:0]       radius_i,
  input  logic [crast_pkg::ColorBits-1:0]       draw_color_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [crast_pkg::PixBits-1:0]  pixel_x_o,
  output logic signed [crast_pkg::PixBits-1:0]  pixel_y_o,
  output logic [crast_pkg::ColorBits-1:0]       pixel_color_o,
  output logic                                  on_screen_o,
  output logic                                  last_of_step_o,
  output logic                                  circle_done_o
);
  import crast_pkg::*;

  logic [ScrBits-1:0] width_q, height_q;
  logic               q_full, q_valid, q_pop, push, in_xfer;
  octant_t            push_data, q_data;

  // Hold the screen size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ScreenWidthRst;
      height_q <= ScreenHeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgScreenWidth:  width_q  <= cfg_wdata_i;
        CfgScreenHeight: height_q <= cfg_wdata_i;
        default:         width_q  <= width_q;
      endcase
    end
  end

  assign in_ready_o = !q_full;
  assign in_xfer    = in_valid_i && !q_full;

  crast_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_transfer_i (in_xfer),
    .opcode_i      (opcode_i),
    .center_x_i    (center_x_i),
    .center_y_i    (center_y_i),
    .radius_i      (radius_i),
    .draw_color_i  (draw_color_i),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  crast_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  crast_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_data_i        (q_data),
    .q_pop_o         (q_pop),
    .screen_width_i  (width_q),
    .screen_height_i (height_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .pixel_color_o   (pixel_color_o),
    .on_screen_o     (on_screen_o),
    .last_of_step_o  (last_of_step_o),
    .circle_done_o   (circle_done_o)
  );

endmodule

@@ src/crast_front.sv @@
module crast_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_transfer_i,
  input  logic                               opcode_i,
  input  logic [crast_pkg::CoordBits-1:0]    center_x_i,
  input  logic [crast_pkg::CoordBits-1:0]    center_y_i,
  input  logic [crast_pkg::CoordBits-1:0]    radius_i,
  input  logic [crast_pkg::ColorBits-1:0]    draw_color_i,
  output logic                               push_o,
  output crast_pkg::octant_t                 push_data_o
);
  import crast_pkg::*;

  logic [CoordBits-1:0] cx_q, cx_d, cy_q, cy_d, ox_q, ox_d, oy_q, oy_d;
  logic [DecBits-1:0]   dec_q, dec_d;
  logic [ColorBits-1:0] color_q, color_d;
  logic                 emit;
  logic [DecBits-1:0]   x4, y4, r2, dec_step;

  assign x4 = {{(DecBits-CoordBits-2){1'b0}}, ox_q, 2'b00};
  assign y4 = {{(DecBits-CoordBits-2){1'b0}}, oy_q, 2'b00};
  assign r2 = {{(DecBits-CoordBits-1){1'b0}}, radius_i, 1'b0};
  // Pick the decision update by the sign of the current value
  assign dec_step = dec_q[DecBits-1] ? dec_q + x4 + DecBits'(6)
                                     : dec_q + x4 - y4 + DecBits'(10);

  // Classify the command and compute the next octant position
  always_comb begin
    cx_d    = cx_q;
    cy_d    = cy_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    dec_d   = dec_q;
    color_d = color_q;
    emit    = 1'b0;
    if (in_transfer_i) begin
      unique case (opcode_i)
        OpStart: begin
          cx_d    = center_x_i;
          cy_d    = center_y_i;
          color_d = draw_color_i;
          ox_d    = '0;
          oy_d    = radius_i;
          dec_d   = DecBits'(3) - r2;
          emit    = 1'b1;
        end
        OpStep: begin
          if (ox_q < oy_q) begin
            dec_d = dec_step;
            ox_d  = ox_q + CoordBits'(1);
            if (!dec_q[DecBits-1]) begin
              oy_d = oy_q - CoordBits'(1);
            end
            emit = 1'b1;
          end
        end
        default: emit = 1'b0;
      endcase
    end
  end

  assign push_o            = emit;
  assign push_data_o.cx    = cx_d;
  assign push_data_o.cy    = cy_d;
  assign push_data_o.ox    = ox_d;
  assign push_data_o.oy    = oy_d;
  assign push_data_o.color = color_d;
  assign push_data_o.done  = (ox_d >= oy_d);

  // Hold the circle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q    <= '0;
      cy_q    <= '0;
      ox_q    <= '0;
      oy_q    <= '0;
      dec_q   <= '0;
      color_q <= '0;
    end else begin
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      ox_q    <= ox_d;
      oy_q    <= oy_d;
      dec_q   <= dec_d;
      color_q <= color_d;
    end
  end

endmodule

@@ src/crast_fifo.sv @@
module crast_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  crast_pkg::octant_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output crast_pkg::octant_t pop_data_o
);
  import crast_pkg::*;

  octant_t    mem_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rptr_q];

  // Advance pointers and count
  always_comb begin
    wptr_d = push_i ? ~wptr_q : wptr_q;
    rptr_d = pop_i ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

@@ src/crast_back.sv @@
module crast_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  q_valid_i,
  input  crast_pkg::octant_t                    q_data_i,
  output logic                                  q_pop_o,
  input  logic [crast_pkg::ScrBits-1:0]         screen_width_i,
  input  logic [crast_pkg::ScrBits-1:0]         screen_height_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [crast_pkg::PixBits-1:0]  pixel_x_o,
  output logic signed [crast_pkg::PixBits-1:0]  pixel_y_o,
  output logic [crast_pkg::ColorBits-1:0]       pixel_color_o,
  output logic                                  on_screen_o,
  output logic                                  last_of_step_o,
  output logic                                  circle_done_o
);
  import crast_pkg::*;

  octant_t              cur_q;
  logic                 busy_q, busy_d;
  logic [2:0]           k_q, k_d;
  logic                 ovalid_q, ovalid_d;
  logic                 load_out, pop;
  logic [CoordBits-1:0] a, b;
  logic [PixBits-1:0]   cx_e, cy_e, a_e, b_e, px, py;
  logic                 vis;
  logic [PixBits-1:0]   px_q, py_q;
  logic [ColorBits-1:0] color_q;
  logic                 vis_q, last_q, done_q;

  assign load_out = busy_q && (!ovalid_q || out_ready_i);
  assign pop      = q_valid_i && (!busy_q || (load_out && (k_q == 3'd7)));
  assign q_pop_o  = pop;

  // Form the point for the current symmetry index
  always_comb begin
    a    = k_q[2] ? cur_q.oy : cur_q.ox;
    b    = k_q[2] ? cur_q.ox : cur_q.oy;
    cx_e = {2'b00, cur_q.cx};
    cy_e = {2'b00, cur_q.cy};
    a_e  = {2'b00, a};
    b_e  = {2'b00, b};
    px   = k_q[0] ? cx_e - a_e : cx_e + a_e;
    py   = k_q[1] ? cy_e - b_e : cy_e + b_e;
    vis  = !px[PixBits-1] && !py[PixBits-1] &&
           (CmpBits'(px[PixBits-2:0]) < CmpBits'(screen_width_i)) &&
           (CmpBits'(py[PixBits-2:0]) < CmpBits'(screen_height_i));
  end

  // Sequence the eight points of each entry
  always_comb begin
    busy_d   = busy_q;
    k_d      = k_q;
    ovalid_d = ovalid_q;
    if (load_out) begin
      ovalid_d = 1'b1;
      k_d      = k_q + 3'd1;
      if (k_q == 3'd7) begin
        busy_d = 1'b0;
      end
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
    if (pop) begin
      busy_d = 1'b1;
      k_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      k_q      <= '0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      k_q      <= k_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Latch the working entry and the output register
  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= q_data_i;
    end
    if (load_out) begin
      px_q    <= px;
      py_q    <= py;
      color_q <= cur_q.color;
      vis_q   <= vis;
      last_q  <= (k_q == 3'd7);
      done_q  <= cur_q.done;
    end
  end

  assign out_valid_o    = ovalid_q;
  assign pixel_x_o      = px_q;
  assign pixel_y_o      = py_q;
  assign pixel_color_o  = color_q;
  assign on_screen_o    = vis_q;
  assign last_of_step_o = last_q;
  assign circle_done_o  = done_q;

endmodule

@@ sim/circle_rasterizer_tb.sv @@
module circle_rasterizer_tb;
  import crast_pkg::*;

  localparam int HoldCycles  = 150;
  localparam int DrainCycles = 8;
  localparam int PhaseItems  = 34;
  localparam int NoPause     = 1 << 30;
  localparam int RunLimit    = 2_000_000;

  // One command on the input channel
  typedef struct packed {
    logic                 op;
    logic [CoordBits-1:0] cx;
    logic [CoordBits-1:0] cy;
    logic [CoordBits-1:0] r;
    logic [ColorBits-1:0] color;
  } cmd_t;

  // One plotted point on the result channel
  typedef struct {
    logic signed [PixBits-1:0] px;
    logic signed [PixBits-1:0] py;
    logic [ColorBits-1:0]      color;
    logic                      vis;
    logic                      last;
    logic                      done;
  } point_t;

  // Directed row: a typed row carries its points spelled out (center copies)
  typedef struct packed {
    cmd_t       cmd;
    logic       typed;
    logic [3:0] n_pts;
    logic       vis;
  } dir_row_t;

  typedef enum int {IdleNone, IdleSend, IdleRecv, IdleBoth} idle_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic                  cfg_idx_i = CfgScreenWidth;
  logic [ScrBits-1:0]    cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  opcode_i = OpStart;
  logic [CoordBits-1:0]  center_x_i = '0;
  logic [CoordBits-1:0]  center_y_i = '0;
  logic [CoordBits-1:0]  radius_i = '0;
  logic [ColorBits-1:0]  draw_color_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic signed [PixBits-1:0] pixel_x_o;
  logic signed [PixBits-1:0] pixel_y_o;
  logic [ColorBits-1:0]  pixel_color_o;
  logic                  on_screen_o;
  logic                  last_of_step_o;
  logic                  circle_done_o;

  circle_rasterizer dut (.*);

  // Circle state and screen size as the block should hold them
  logic [ScrBits-1:0]          scr_w = ScreenWidthRst;
  logic [ScrBits-1:0]          scr_h = ScreenHeightRst;
  logic [CoordBits-1:0]        ctr_col = '0;
  logic [CoordBits-1:0]        ctr_row = '0;
  logic [CoordBits-1:0]        off_x = '0;
  logic [CoordBits-1:0]        off_y = '0;
  logic signed [DecBits-1:0]   dec = '0;
  logic [ColorBits-1:0]        ink = '0;

  point_t     expected_pts[$];
  int         n_mismatch = 0;
  idle_mode_e idle_mode = IdleNone;
  int         hold_req = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  dir_row_t   dir_tbl [21];

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(RunLimit);
    $display("Mismatches found");
    $finish;
  end

  // Apply one command to the circle state and list the points it plots
  function automatic int trace_command(input cmd_t c, output point_t pts[8]);
    int d;
    int x;
    int y;
    int a;
    int b;
    int px;
    int py;
    if (c.op == OpStart) begin
      ctr_col = c.cx;
      ctr_row = c.cy;
      ink = c.color;
      off_x = '0;
      off_y = c.r;
      dec = DecBits'(3 - 2 * int'(c.r));
    end else begin
      // nothing left to draw once x has caught up with y
      if (off_x >= off_y) return 0;
      d = int'(dec);
      x = int'(off_x);
      y = int'(off_y);
      if (d < 0) begin
        d = d + 4 * x + 6;
      end else begin
        d = d + 4 * (x - y) + 10;
        off_y = off_y - 1'b1;
      end
      dec = DecBits'(d);
      off_x = off_x + 1'b1;
    end
    x = int'(off_x);
    y = int'(off_y);
    // octant order: (+x,+y) (-x,+y) (+x,-y) (-x,-y), then x and y swapped
    for (int k = 0; k < 8; k++) begin
      a = (k < 4) ? x : y;
      b = (k < 4) ? y : x;
      px = int'(ctr_col) + ((k % 2 == 1) ? -a : a);
      py = int'(ctr_row) + ((k % 4 >= 2) ? -b : b);
      pts[k].px = PixBits'(px);
      pts[k].py = PixBits'(py);
      pts[k].color = ink;
      pts[k].vis = (px >= 0) && (py >= 0) && (px < int'(scr_w)) && (py < int'(scr_h));
      pts[k].last = (k == 7);
      pts[k].done = (off_x >= off_y);
    end
    return 8;
  endfunction

  function automatic bit sender_idles();
    case (idle_mode)
      IdleSend: return $urandom_range(99) < 56;
      IdleBoth: return $urandom_range(99) < 13;
      default:  return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IdleRecv: return $urandom_range(99) < 56;
      IdleBoth: return $urandom_range(99) < 13;
      default:  return 1'b0;
    endcase
  endfunction

  // Check each point transfer, then pick the ready level for the next cycle
  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pts.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected pixel: x=%0d y=%0d color=%06h", pixel_x_o, pixel_y_o,
                   pixel_color_o);
      end else begin
        want = expected_pts.pop_front();
        if (want.px !== pixel_x_o || want.py !== pixel_y_o ||
            want.color !== pixel_color_o || want.vis !== on_screen_o ||
            want.last !== last_of_step_o || want.done !== circle_done_o) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display({"pixel mismatch: want x=%0d y=%0d c=%06h on=%0b last=%0b done=%0b,",
                      " got x=%0d y=%0d c=%06h on=%0b last=%0b done=%0b"},
                     want.px, want.py, want.color, want.vis, want.last, want.done,
                     pixel_x_o, pixel_y_o, pixel_color_o, on_screen_o, last_of_step_o,
                     circle_done_o);
        end
      end
    end
    // long hold-off when asked for, random stalls otherwise
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !receiver_stalls();
    end
  end

  // Offer one command and return at the edge of its transfer
  task automatic send_cmd(input cmd_t c);
    while (sender_idles()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= c.op;
    center_x_i <= c.cx;
    center_y_i <= c.cy;
    radius_i <= c.r;
    draw_color_i <= c.color;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic issue(input cmd_t c, output int n);
    point_t pts[8];
    send_cmd(c);
    n = trace_command(c, pts);
    for (int k = 0; k < n; k++) expected_pts.push_back(pts[k]);
  endtask

  // Drop valid and let every expected point drain out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_pts.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_screen(input logic [ScrBits-1:0] w, input logic [ScrBits-1:0] h);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgScreenWidth;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    scr_w = w;
    cfg_idx_i <= CfgScreenHeight;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    scr_h = h;
    cfg_we_i <= 1'b0;
  endtask

  // Center near the array ends or near the screen border most of the time
  function automatic logic [CoordBits-1:0] pick_coord(input int bound);
    int v;
    case ($urandom_range(3))
      0: v = int'($urandom_range(0, 1023));
      1: v = int'($urandom_range(0, 24));
      2: v = 1023 - int'($urandom_range(0, 24));
      default: v = bound - 12 + int'($urandom_range(0, 24));
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return CoordBits'(v);
  endfunction

  function automatic logic [CoordBits-1:0] pick_radius();
    case ($urandom_range(9))
      0:       return CoordBits'($urandom_range(0, 1023));
      1, 2:    return CoordBits'($urandom_range(25, 100));
      default: return CoordBits'($urandom_range(0, 24));
    endcase
  endfunction

  function automatic cmd_t random_cmd(input logic op);
    cmd_t c;
    c.op = op;
    c.cx = CoordBits'($urandom());
    c.cy = CoordBits'($urandom());
    c.r = CoordBits'($urandom());
    c.color = ColorBits'($urandom());
    return c;
  endfunction

  // Mostly whole circles (start, then steps to the end), some noise
  task automatic run_random(input int budget, input int pause_at);
    int   emitted;
    int   n;
    int   steps;
    bit   paused;
    cmd_t c;
    emitted = 0;
    paused = 1'b0;
    while (emitted < budget) begin
      if (!paused && emitted >= pause_at) begin
        paused = 1'b1;
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (expected_pts.size() != 0);
      end
      if ($urandom_range(99) < 85) begin
        c = random_cmd(OpStart);
        c.cx = pick_coord(int'(scr_w));
        c.cy = pick_coord(int'(scr_h));
        c.r = pick_radius();
        issue(c, n);
        emitted += (n != 0);
        // cut large circles short, and some small ones too
        steps = (c.r > 60 || $urandom_range(4) == 0) ? int'($urandom_range(1, 12)) : 1024;
        while (steps > 0 && off_x < off_y && emitted < budget) begin
          issue(random_cmd(OpStep), n);
          emitted += (n != 0);
          steps--;
        end
        if ($urandom_range(9) == 0) begin
          issue(random_cmd(OpStep), n);
          emitted += (n != 0);
        end
      end else begin
        issue(random_cmd(1'($urandom_range(1))), n);
        emitted += (n != 0);
      end
    end
  endtask

  task automatic run_phase(input logic [ScrBits-1:0] w, input logic [ScrBits-1:0] h,
                           input idle_mode_e mode, input bit hold, input int pause_at);
    set_screen(w, h);
    idle_mode = mode;
    if (hold) hold_req++;
    run_random(PhaseItems, pause_at);
    wait_idle();
  endtask

  initial begin
    dir_row_t row;
    point_t   pt;
    point_t   pts[8];
    int       n;
    dir_tbl = '{
      // step before any start: nothing
      '{'{OpStep,  10'd0,    10'd0,    10'd0,    24'h000000}, 1'b1, 4'd0, 1'b0},
      // zero radius: eight copies of the center
      '{'{OpStart, 10'd5,    10'd7,    10'd0,    24'h000000}, 1'b1, 4'd8, 1'b1},
      // step on a finished circle, junk fields
      '{'{OpStep,  10'd1023, 10'd1023, 10'd1023, 24'hFFFFFF}, 1'b1, 4'd0, 1'b0},
      '{'{OpStart, 10'd0,    10'd0,    10'd1023, 24'hFFFFFF}, 1'b0, 4'd0, 1'b0},
      '{'{OpStep,  10'd0,    10'd0,    10'd0,    24'h000000}, 1'b0, 4'd0, 1'b0},
      '{'{OpStep,  10'd1023, 10'd1023, 10'd1023, 24'hFFFFFF}, 1'b0, 4'd0, 1'b0},
      '{'{OpStart, 10'd1023, 10'd1023, 10'd0,    24'hFFFFFF}, 1'b1, 4'd8, 1'b0},
      '{'{OpStart, 10'd1023, 10'd0,    10'd3,    24'hA5A5A5}, 1'b0, 4'd0, 1'b0},
      '{'{OpStep,  10'd0,    10'd0,    10'd0,    24'h000000}, 1'b0, 4'd0, 1'b0},
      '{'{OpStep,  10'd0,    10'd0,    10'd0,    24'h000000}, 1'b0, 4'd0, 1'b0},
      '{'{OpStep,  10'd0,    10'd0,    10'd0,    24'h000000}, 1'b1, 4'd0, 1'b0},
      '{'{OpStart, 10'd511,  10'd383,  10'd1,    24'h5A5A5A}, 1'b0, 4'd0, 1'b0},
      '{'{OpStep,  10'd0,    10'd0,    10'd0,    24'h000000}, 1'b0, 4'd0, 1'b0},
      '{'{OpStep,  10'd0,    10'd0,    10'd0,    24'h000000}, 1'b1, 4'd0, 1'b0},
      '{'{OpStart, 10'd256,  10'd192,  10'd10,   24'h123456}, 1'b0, 4'd0, 1'b0},
      '{'{OpStep,  10'd0,    10'd0,    10'd0,    24'h000000}, 1'b0, 4'd0, 1'b0},
      '{'{OpStep,  10'd0,    10'd0,    10'd0,    24'h000000}, 1'b0, 4'd0, 1'b0},
      '{'{OpStep,  10'd0,    10'd0,    10'd0,    24'h000000}, 1'b0, 4'd0, 1'b0},
      // restart in the middle of a circle
      '{'{OpStart, 10'd0,    10'd1023, 10'd1023, 24'h800001}, 1'b0, 4'd0, 1'b0},
      '{'{OpStep,  10'd0,    10'd0,    10'd0,    24'h000000}, 1'b0, 4'd0, 1'b0},
      '{'{OpStep,  10'd0,    10'd0,    10'd0,    24'h000000}, 1'b0, 4'd0, 1'b0}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed commands under the reset screen size
    foreach (dir_tbl[i]) begin
      row = dir_tbl[i];
      if (row.typed) begin
        send_cmd(row.cmd);
        void'(trace_command(row.cmd, pts));
        for (int k = 0; k < row.n_pts; k++) begin
          pt.px = $signed({2'b00, row.cmd.cx});
          pt.py = $signed({2'b00, row.cmd.cy});
          pt.color = row.cmd.color;
          pt.vis = row.vis;
          pt.last = (k == 7);
          pt.done = 1'b1;
          expected_pts.push_back(pt);
        end
      end else begin
        issue(row.cmd, n);
      end
    end
    wait_idle();

    // random phases, each with its own screen size and idle pattern
    run_phase(11'd1024, 11'd1024, IdleNone, 1'b1, NoPause);
    run_phase(11'd0,    11'd0,    IdleSend, 1'b0, NoPause);
    run_phase(11'd2047, 11'd2047, IdleRecv, 1'b0, NoPause);
    run_phase(11'd1,    11'd1,    IdleBoth, 1'b0, NoPause);
    run_phase(11'd640,  11'd480,  IdleSend, 1'b0, PhaseItems / 2);
    run_phase(11'd512,  11'd384,  IdleRecv, 1'b1, NoPause);

    if (n_mismatch == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
